@@ hw/rtl/fsed_pkg.sv @@
// shared types and constants of the frame select-every decimator
`default_nettype none

package fsed_pkg;

  localparam int GROUP_W   = 9;
  localparam int PICK_W    = 8;
  localparam int POS_W     = 8;
  localparam int ID_W      = 32;
  localparam int STAMP_W   = 62;
  localparam int FDUR_W    = 32;
  localparam int SUM_W     = 48;
  localparam int PROD_W    = SUM_W + GROUP_W;
  localparam int DIVISOR_W = POS_W + 1;
  localparam int CNT_W     = $clog2(PROD_W);

  // input transaction kinds
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic {
    CFG_GROUP_SIZE    = 1'b0,
    CFG_PICK_POSITION = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [PROD_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/fsed_div.sv @@
// restoring radix-2 divider, one quotient bit per cycle
`default_nettype none

module fsed_div
  import fsed_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvsr_r, dvsr_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;

  logic [DIVISOR_W:0]   rem_shift;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 fits;

  assign rem_shift = {rem_r, quo_r[PROD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvsr_r};
  assign fits      = rem_shift >= {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_LAST;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the low bits
      rem_nxt = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    quo_r  <= quo_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/frame_select_every_decimator_unit.sv @@
// top level of the frame select-every decimator
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | sink      | in_valid/in_stall  | func, frame_id, time_stamp, frame_duration
//  out     | source    | out_valid/out_stall| out_frame_id, out_time_stamp, out_duration
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data (group_size, pick_position)
//
// a normal frame's result goes straight into the output register
// a flush that emits starts the bit-serial divider (duration_sum * size over position + 1)
//   when it is taken; once done is seen, the result is loaded into the output register
//   when that is free, and only then is the next transaction taken
// a flush that emits nothing leaves the state machine idle
// reset is synchronous and clears the group state and restores the register defaults
// the input stalls while a flush divides or waits for the output register, and while a held result is itself stalled
`default_nettype none

module frame_select_every_decimator_unit
  import fsed_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [GROUP_W-1:0] cfg_data,
  // input transactions
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic [ID_W-1:0]    in_frame_id,
  input  wire logic [STAMP_W-1:0] in_time_stamp,
  input  wire logic [FDUR_W-1:0]  in_frame_duration,
  // result transactions
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ID_W-1:0]         out_frame_id,
  output logic [STAMP_W-1:0]      out_time_stamp,
  output logic [SUM_W-1:0]        out_duration
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT
  } state_t;

  state_t              state_r, state_nxt;

  // configuration
  logic [GROUP_W-1:0]  group_size_r, group_size_nxt;
  logic [PICK_W-1:0]   pick_position_r, pick_position_nxt;

  // group state
  logic [POS_W-1:0]    group_position_r, group_position_nxt;
  logic [SUM_W-1:0]    duration_sum_r, duration_sum_nxt;
  logic [STAMP_W-1:0]  group_start_stamp_r, group_start_stamp_nxt;
  logic                stamp_valid_r, stamp_valid_nxt;
  logic [ID_W-1:0]     kept_frame_id_r, kept_frame_id_nxt;

  // flush result id held while dividing
  logic [ID_W-1:0]     flush_id_r, flush_id_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_frame_id_r, out_frame_id_nxt;
  logic [STAMP_W-1:0]  out_time_stamp_r, out_time_stamp_nxt;
  logic [SUM_W-1:0]    out_duration_r, out_duration_nxt;

  logic [GROUP_W-1:0]  size;
  logic [GROUP_W-1:0]  size_m1;
  logic [POS_W-1:0]    last;
  logic [GROUP_W-1:0]  half;
  logic                flush_ok;
  logic                group_end;
  logic                out_free;
  logic                accept;

  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_sat;
  logic [STAMP_W-1:0]  stamp_upd;
  logic [ID_W-1:0]     kept_upd;
  logic [PROD_W-1:0]   product;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // effective group size: zero acts as one, above 256 acts as 256
  always_comb begin
    priority if (group_size_r == '0) begin
      size = GROUP_W'(1);
    end else if (group_size_r > GROUP_W'(256)) begin
      size = GROUP_W'(256);
    end else begin
      size = group_size_r;
    end
  end

  assign size_m1   = size - GROUP_W'(1);
  assign last      = size_m1[POS_W-1:0];
  assign half      = size >> 1;
  assign flush_ok  = (group_position_r < last) && ({1'b0, group_position_r} >= half);
  assign group_end = group_position_r >= last;

  // saturating duration accumulate
  assign sum_ext   = {1'b0, duration_sum_r} + (SUM_W + 1)'(in_frame_duration);
  assign sum_sat   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign stamp_upd = stamp_valid_r ? group_start_stamp_r : in_time_stamp;
  assign kept_upd  = (group_position_r == pick_position_r) ? in_frame_id : kept_frame_id_r;

  // scale to a full group, 48 x 9 bits, registered inside the divider
  assign product   = PROD_W'(duration_sum_r) * PROD_W'(size);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt             = state_r;
    group_size_nxt        = group_size_r;
    pick_position_nxt     = pick_position_r;
    group_position_nxt    = group_position_r;
    duration_sum_nxt      = duration_sum_r;
    group_start_stamp_nxt = group_start_stamp_r;
    stamp_valid_nxt       = stamp_valid_r;
    kept_frame_id_nxt     = kept_frame_id_r;
    flush_id_nxt          = flush_id_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_frame_id_nxt      = out_frame_id_r;
    out_time_stamp_nxt    = out_time_stamp_r;
    out_duration_nxt      = out_duration_r;
    div_req.start         = 1'b0;
    div_req.dividend      = product;
    div_req.divisor       = {1'b0, group_position_r} + DIVISOR_W'(1);

    // the user must write the registers only while idle; the block itself does not enforce this
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GROUP_SIZE:    group_size_nxt    = cfg_data;
        CFG_PICK_POSITION: pick_position_nxt = cfg_data[PICK_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_FLUSH) begin
            // flush leaves the group untouched
            if (flush_ok) begin
              flush_id_nxt  = (group_position_r < pick_position_r) ? in_frame_id
                                                                    : kept_frame_id_r;
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end else begin
            kept_frame_id_nxt = kept_upd;
            if (group_end) begin
              out_valid_nxt      = 1'b1;
              out_frame_id_nxt   = kept_upd;
              out_time_stamp_nxt = stamp_upd;
              out_duration_nxt   = sum_sat;
              group_position_nxt = '0;
              duration_sum_nxt   = '0;
              stamp_valid_nxt    = 1'b0;
              group_start_stamp_nxt = stamp_upd;
            end else begin
              group_position_nxt    = group_position_r + POS_W'(1);
              duration_sum_nxt      = sum_sat;
              group_start_stamp_nxt = stamp_upd;
              stamp_valid_nxt       = 1'b1;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // quotient holds until the next start
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_frame_id_nxt   = flush_id_r;
          out_time_stamp_nxt = group_start_stamp_r;
          out_duration_nxt   = (|div_rsp.quotient[PROD_W-1:SUM_W]) ? {SUM_W{1'b1}}
                                                                   : div_rsp.quotient[SUM_W-1:0];
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    flush_id_r       <= flush_id_nxt;
    out_frame_id_r   <= out_frame_id_nxt;
    out_time_stamp_r <= out_time_stamp_nxt;
    out_duration_r   <= out_duration_nxt;
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      group_size_r        <= GROUP_W'(1);
      pick_position_r     <= '0;
      group_position_r    <= '0;
      duration_sum_r      <= '0;
      group_start_stamp_r <= '0;
      stamp_valid_r       <= 1'b0;
      kept_frame_id_r     <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      state_r             <= state_nxt;
      group_size_r        <= group_size_nxt;
      pick_position_r     <= pick_position_nxt;
      group_position_r    <= group_position_nxt;
      duration_sum_r      <= duration_sum_nxt;
      group_start_stamp_r <= group_start_stamp_nxt;
      stamp_valid_r       <= stamp_valid_nxt;
      kept_frame_id_r     <= kept_frame_id_nxt;
      out_valid_r         <= out_valid_nxt;
    end
  end

  fsed_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_frame_id   = out_frame_id_r;
  assign out_time_stamp = out_time_stamp_r;
  assign out_duration   = out_duration_r;

  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // a normal frame that closes a group clears the group state
  a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_FRAME && group_end) |=> (group_position_r == '0
                                           && !stamp_valid_r && duration_sum_r == '0))
    else $error("group state not cleared at group end");

  // flush never changes the group state
  a_flush_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_FLUSH) |=> ($stable(duration_sum_r)
                             && $stable(group_position_r) && $stable(kept_frame_id_r)))
    else $error("flush changed group state");

  // a finished flush always lands in the output register
  a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("flush result not loaded");

endmodule

`default_nettype wire

@@ verif/tb_frame_select_every_decimator_unit.sv @@
// self-checking testbench of the frame select-every decimator
`timescale 1ns / 100ps

module tb_frame_select_every_decimator_unit;
  import fsed_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX     = '1;
  localparam int               SETTLE_CYC  = 90;      // long enough for a running flush divide
  localparam int               CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic               func;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
    logic [FDUR_W-1:0]  dur;
  } frame_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
    logic [SUM_W-1:0]   dur;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_GROUP_SIZE;
  logic [GROUP_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = FUNC_FRAME;
  logic [ID_W-1:0]    in_frame_id = '0;
  logic [STAMP_W-1:0] in_time_stamp = '0;
  logic [FDUR_W-1:0]  in_frame_duration = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ID_W-1:0]    out_frame_id;
  logic [STAMP_W-1:0] out_time_stamp;
  logic [SUM_W-1:0]   out_duration;

  frame_select_every_decimator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_frame_id       (in_frame_id),
    .in_time_stamp     (in_time_stamp),
    .in_frame_duration (in_frame_duration),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_id      (out_frame_id),
    .out_time_stamp    (out_time_stamp),
    .out_duration      (out_duration)
  );

  // mirror of the block: register copies and group state, reset values
  logic [GROUP_W-1:0] group_size_reg = 9'd1;
  logic [PICK_W-1:0]  pick_reg = '0;
  logic [POS_W-1:0]   group_pos = '0;
  logic [SUM_W-1:0]   group_dur_sum = '0;
  logic [STAMP_W-1:0] group_first_stamp = '0;
  logic               first_stamp_held = 1'b0;
  logic [ID_W-1:0]    kept_id = '0;

  // decimated frames predicted but not yet seen on the result channel
  frame_result_t decimated_due[$];
  frame_result_t decimated_want;

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // applies one accepted transaction to the mirror and queues its result, if any
  task automatic decimate_frame(input frame_item_t it);
    int unsigned   size;
    int unsigned   pos;
    logic [63:0]   scaled;
    logic [SUM_W:0] wide_sum;
    frame_result_t res;
    // register value 0 behaves as 1, anything above 256 as 256
    size = (group_size_reg == 0) ? 1 : (group_size_reg > 256) ? 256 : group_size_reg;
    pos  = group_pos;
    if (it.func == FUNC_FLUSH) begin
      // partial group of at least half a group, not already at its end
      if (pos < size - 1 && pos >= size / 2) begin
        scaled = (64'(group_dur_sum) * 64'(size)) / 64'(pos + 1);
        if (scaled > 64'(SUM_MAX))
          scaled = 64'(SUM_MAX);
        // pick not yet reached: the flush transaction's own id stands in
        res.id    = (pos < pick_reg) ? it.id : kept_id;
        res.stamp = group_first_stamp;
        res.dur   = scaled[SUM_W-1:0];
        decimated_due.push_back(res);
      end
    end else begin
      if (!first_stamp_held) begin
        group_first_stamp = it.stamp;
        first_stamp_held  = 1'b1;
      end
      wide_sum = {1'b0, group_dur_sum} + (SUM_W+1)'(it.dur);
      group_dur_sum = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
      if (pos == pick_reg)
        kept_id = it.id;
      // a position past the end (after a shrink) also closes the group
      if (pos >= size - 1) begin
        res.id    = kept_id;
        res.stamp = group_first_stamp;
        res.dur   = group_dur_sum;
        decimated_due.push_back(res);
        group_pos        = '0;
        group_dur_sum    = '0;
        first_stamp_held = 1'b0;
      end else begin
        group_pos = group_pos + 1'b1;
      end
    end
  endtask

  // drives one transaction, with random idle cycles ahead of it
  task automatic send_frame(input frame_item_t it);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_func           <= it.func;
    in_frame_id       <= it.id;
    in_time_stamp     <= it.stamp;
    in_frame_duration <= it.dur;
    do @(posedge clk); while (in_stall);
    decimate_frame(it);
  endtask

  // lowers valid, waits for every due result and lets a running divide finish
  task automatic settle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (decimated_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [GROUP_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GROUP_SIZE)
      group_size_reg = val;
    else
      pick_reg = val[PICK_W-1:0];
  endtask

  task automatic configure(input logic [GROUP_W-1:0] size, input logic [GROUP_W-1:0] pick);
    settle();
    write_reg(CFG_GROUP_SIZE, size);
    write_reg(CFG_PICK_POSITION, pick);
  endtask

  function automatic frame_item_t mk(input logic func, input logic [ID_W-1:0] id,
                                     input logic [STAMP_W-1:0] stamp,
                                     input logic [FDUR_W-1:0] dur);
    frame_item_t it;
    it.func  = func;
    it.id    = id;
    it.stamp = stamp;
    it.dur   = dur;
    return it;
  endfunction

  // random content, with the all-zero and all-one corners mixed in
  function automatic frame_item_t random_frame(input logic func);
    frame_item_t it;
    logic [63:0] wide;
    wide     = {$urandom(), $urandom()};
    it.func  = func;
    it.id    = $urandom();
    it.stamp = wide[STAMP_W-1:0];
    case ($urandom_range(9))
      0:       it.dur = '0;
      1:       it.dur = '1;
      default: it.dur = $urandom();
    endcase
    if ($urandom_range(19) == 0)
      it.stamp = ($urandom_range(1) != 0) ? '1 : '0;
    return it;
  endfunction

  // register defaults: every frame is its own group
  task automatic test_reset_defaults;
    send_frame(mk(FUNC_FRAME, '1, '1, '1));
    send_frame(mk(FUNC_FRAME, '0, '0, '0));
    send_frame(mk(FUNC_FLUSH, 32'h0000_0f1f, '1, '1));
  endtask

  // flush below half a group, inside the window, repeated, and at the last position
  task automatic test_flush_window;
    configure(9'd4, 9'd1);
    send_frame(mk(FUNC_FRAME, 32'ha000_0001, 62'h0123_4567_89ab_cdef, 32'd1000));
    send_frame(mk(FUNC_FLUSH, 32'hf000_0001, '0, '0));
    send_frame(mk(FUNC_FRAME, 32'ha000_0002, 62'h1, 32'hffff_ffff));
    send_frame(mk(FUNC_FLUSH, 32'hf000_0002, '1, '1));
    send_frame(mk(FUNC_FLUSH, 32'hf000_0003, '1, '1));
    send_frame(mk(FUNC_FRAME, 32'ha000_0003, 62'h2, 32'd7));
    send_frame(mk(FUNC_FLUSH, 32'hf000_0004, '0, '0));
    send_frame(mk(FUNC_FRAME, 32'ha000_0004, 62'h3, 32'd9));
    // pick later than the flush point: flush id is used
    configure(9'd4, 9'd3);
    send_frame(mk(FUNC_FRAME, 32'hb000_0001, 62'h3fff_0000_0000_0001, 32'd11));
    send_frame(mk(FUNC_FRAME, 32'hb000_0002, 62'h5, 32'd13));
    send_frame(mk(FUNC_FLUSH, 32'hf000_0005, '0, '0));
    send_frame(mk(FUNC_FRAME, 32'hb000_0003, 62'h6, 32'd17));
    send_frame(mk(FUNC_FRAME, 32'hb000_0004, 62'h7, 32'd19));
  endtask

  // pick beyond the group: the flush uses its own id and the previously kept id carries over
  task automatic test_pick_unreached;
    configure(9'd4, 9'd5);
    send_frame(mk(FUNC_FRAME, 32'hc000_0001, 62'h10, 32'd1));
    send_frame(mk(FUNC_FRAME, 32'hc000_0002, 62'h11, 32'd2));
    send_frame(mk(FUNC_FLUSH, 32'hf000_0006, '0, '0));
    send_frame(mk(FUNC_FRAME, 32'hc000_0003, 62'h12, 32'd3));
    send_frame(mk(FUNC_FRAME, 32'hc000_0004, 62'h13, 32'd4));
  endtask

  // group shrinks under a partial group: flush blocked, next frame closes it
  task automatic test_resize_midgroup;
    configure(9'd8, 9'd2);
    for (int i = 0; i < 6; i++)
      send_frame(mk(FUNC_FRAME, 32'hd000_0000 + i, 62'h20 + i, 32'd100 + i));
    configure(9'd4, 9'd2);
    send_frame(mk(FUNC_FLUSH, 32'hf000_0007, '0, '0));
    send_frame(mk(FUNC_FRAME, 32'hd000_0006, 62'h26, 32'd106));
  endtask

  // size 0, size 2, and the largest group with the largest pick
  task automatic test_size_extremes;
    configure(9'd0, 9'd0);
    send_frame(random_frame(FUNC_FRAME));
    send_frame(random_frame(FUNC_FRAME));
    send_frame(random_frame(FUNC_FLUSH));
    configure(9'd2, 9'd1);
    send_frame(random_frame(FUNC_FRAME));
    send_frame(random_frame(FUNC_FLUSH));
    send_frame(random_frame(FUNC_FRAME));
    // 511 acts as 256; one full group of maximal durations
    configure(9'd511, 9'd255);
    repeat (256) send_frame(mk(FUNC_FRAME, $urandom(), '1, '1));
    repeat (200) send_frame(random_frame(FUNC_FRAME));
    send_frame(random_frame(FUNC_FLUSH));
    // exact 256 written under the partial group
    configure(9'd256, 9'd0);
    send_frame(random_frame(FUNC_FLUSH));
    repeat (56) send_frame(random_frame(FUNC_FRAME));
  endtask

  // random segments: each one reprograms the registers, then frames with sparse flushes
  task automatic test_random_traffic;
    int                 sent;
    int unsigned        eff;
    int unsigned        flush_pct;
    int unsigned        nframes;
    int unsigned        r;
    logic [GROUP_W-1:0] size;
    logic [PICK_W-1:0]  pick;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 200) begin
        r = $urandom_range(99);
        if (r < 4)
          size = '0;
        else if (r < 8)
          size = GROUP_W'($urandom_range(511, 129));
        else if (r < 20)
          size = GROUP_W'($urandom_range(64, 17));
        else
          size = GROUP_W'($urandom_range(16, 1));
        eff = (size == 0) ? 1 : (size > 256) ? 256 : size;
        // mostly a reachable pick, sometimes a random one that may lie past the group
        pick = ($urandom_range(9) < 7) ? PICK_W'($urandom_range(eff - 1)) : PICK_W'($urandom());
        configure(size, {1'($urandom_range(1)), pick});
        nframes   = $urandom_range(50, 10);
        flush_pct = $urandom_range(25, 5);
        repeat (nframes) begin
          send_frame(random_frame(($urandom_range(99) < flush_pct) ? FUNC_FLUSH : FUNC_FRAME));
          sent++;
        end
      end
    end
  endtask

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decimated_due.size() == 0) begin
        report_mismatch("unexpected result, frame id", 64'(out_frame_id), 64'd0);
      end else begin
        decimated_want = decimated_due.pop_front();
        if (out_frame_id !== decimated_want.id)
          report_mismatch("frame id", 64'(out_frame_id), 64'(decimated_want.id));
        if (out_time_stamp !== decimated_want.stamp)
          report_mismatch("time stamp", 64'(out_time_stamp), 64'(decimated_want.stamp));
        if (out_duration !== decimated_want.dur)
          report_mismatch("duration", 64'(out_duration), 64'(decimated_want.dur));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("frame_select_every_decimator_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed part under light sender idling and heavy receiver stalls
    send_idle_pct = 18;
    recv_idle_pct = 74;
    test_reset_defaults();
    test_flush_window();
    test_pick_unreached();
    test_resize_midgroup();
    test_size_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("frame_select_every_decimator_unit regression: pass");
    end else begin
      $display("frame_select_every_decimator_unit regression: fail");
    end
    $finish;
  end

endmodule
